FILE: rtl/thermal_pwm_fan_with_tacho_unit_macros.svh
// Assertion macros for the thermal PWM fan unit.
// Users must have clk and rst_n in scope.
`ifndef THERMAL_PWM_FAN_WITH_TACHO_UNIT_MACROS_SVH
`define THERMAL_PWM_FAN_WITH_TACHO_UNIT_MACROS_SVH

// same-cycle implication
`define TPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tpf_pkg.sv
// Package for the thermal PWM fan unit: constants, codes and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package tpf_pkg;

  localparam int unsigned SAMPLE_MS = 1000;
  localparam logic [7:0]  MIN_DUTY  = 8'd0;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int TEMP_W    = 12;
  localparam int CNT_W     = 16;
  localparam int PCT_W     = 7;
  localparam int DUTY_W    = 8;

  localparam logic [CNT_W-1:0] RPM_NUM  = 16'd60000;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_KNEE = 7'd30;
  localparam int unsigned      PCT_SPAN = 70;

  // reciprocal of the span, exact for products up to 255 * 70
  localparam int unsigned RECIP_SH = 20;
  localparam int unsigned RECIP    = ((1 << RECIP_SH) + PCT_SPAN - 1) / PCT_SPAN;

  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 20;
  localparam int DIV_CNT_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_MODE    = 3'd0,
    CFG_FAN_ENABLE   = 3'd1,
    CFG_MANUAL_SPEED = 3'd2,
    CFG_TEMP_LOW     = 3'd3,
    CFG_TEMP_HIGH    = 3'd4,
    CFG_START_DUTY   = 3'd5,
    CFG_MAX_DUTY     = 3'd6,
    CFG_PULSES_TURN  = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_TACHO = 2'd1,
    MODE_TEMP  = 2'd2
  } item_mode_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic rpm_mul;
    logic rpm_div;
    logic rpm_load;
    logic tmp_div;
    logic speed_load;
    logic map_mul;
    logic map_scl;
    logic map_fin;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_rpm;
    logic need_tdiv;
    logic need_map;
    logic div_done;
  } dp_sts_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [CNT_W-1:0]  rpm;
    logic [PCT_W-1:0]  speed_percent;
    logic              fan_on;
    logic              rpm_fresh;
  } result_t;

endpackage

FILE: rtl/tpf_in_if.sv
// Input channel of the thermal PWM fan unit: valid/ready plus item fields.
// Depends on tpf_pkg.
`timescale 1ns / 1ps

interface tpf_in_if
  import tpf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [TEMP_W-1:0] temperature;

  modport source (output valid, output mode, output temperature, input ready);
  modport sink   (input valid, input mode, input temperature, output ready);
endinterface

FILE: rtl/tpf_out_if.sv
// Result channel of the thermal PWM fan unit: valid/ready plus result fields.
// Depends on tpf_pkg.
`timescale 1ns / 1ps

interface tpf_out_if
  import tpf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty;
  logic [CNT_W-1:0]  rpm;
  logic [PCT_W-1:0]  speed_percent;
  logic              fan_on;
  logic              rpm_fresh;

  modport source (output valid, output duty, output rpm, output speed_percent,
                  output fan_on, output rpm_fresh, input ready);
  modport sink   (input valid, input duty, input rpm, input speed_percent,
                  input fan_on, input rpm_fresh, output ready);
endinterface

FILE: rtl/thermal_pwm_fan_with_tacho_unit.sv
// Top level of the thermal PWM fan unit with tachometer.
// Depends on tpf_pkg, tpf_in_if, tpf_out_if, tpf_ctrl and tpf_dp.
//
//   port     | dir | carries
//   ---------+-----+-----------------------------------------------
//   in_ch    | in  | mode, temperature (valid/ready)
//   out_ch   | out | duty, rpm, speed_percent, fan_on, rpm_fresh
//   cfg_*    | in  | register write: cfg_we, cfg_index, cfg_data
//
// One transaction at a time. Tacho edges and plain ticks pass through the
// execute step; a tick that closes a window adds the rpm multiply and the
// 32-step shared divider, a temperature sample in auto mode between the
// thresholds the divider; duty mapping adds its multiply, scale and finish.
// Synchronous active-low reset restores the register defaults.
// The result sits in an output register; a stalled output holds the next
// transaction in its final step until the register frees.
`timescale 1ns / 1ps

module thermal_pwm_fan_with_tacho_unit
  import tpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  tpf_in_if.sink               in_ch,
  tpf_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    out_free;
  logic    in_ready;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;

  tpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_mode        (in_ch.mode),
    .in_temperature (in_ch.temperature),
    .cmd            (cmd),
    .sts            (sts),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) res_r <= res;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.duty          = res_r.duty;
  assign out_ch.rpm           = res_r.rpm;
  assign out_ch.speed_percent = res_r.speed_percent;
  assign out_ch.fan_on        = res_r.fan_on;
  assign out_ch.rpm_fresh     = res_r.rpm_fresh;

endmodule

FILE: rtl/tpf_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tpf_pkg.
`timescale 1ns / 1ps

module tpf_div
  import tpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DIV_NUM_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    ge       = rem_sh >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_NUM_W - 1);
      rem_nxt  = '0;
      den_nxt  = den;
      quo_nxt  = num;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      quo_nxt = {quo_r[DIV_NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: rtl/tpf_dp.sv
// Datapath: configuration registers, fan state, rpm and speed arithmetic.
// Depends on tpf_pkg and tpf_div.
`timescale 1ns / 1ps

module tpf_dp
  import tpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [1:0]           in_mode,
  input  logic [TEMP_W-1:0]    in_temperature,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  output result_t              res
);

  // configuration
  logic                     auto_mode_r;
  logic                     fan_enable_r;
  logic [PCT_W-1:0]         manual_speed_r;
  logic signed [TEMP_W-1:0] temp_low_r;
  logic signed [TEMP_W-1:0] temp_high_r;
  logic [DUTY_W-1:0]        start_duty_r;
  logic [DUTY_W-1:0]        max_duty_r;
  logic [3:0]               ppr_r;

  // fan state
  logic [PCT_W-1:0]  auto_speed_r;
  logic              auto_on_r;
  logic [DUTY_W-1:0] duty_r;
  logic [CNT_W-1:0]  pulses_r;
  logic [CNT_W-1:0]  ticks_r;
  logic [CNT_W-1:0]  rpm_r;
  logic              fresh_r;

  // per-transaction working registers
  logic [1:0]               mode_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [TEMP_W:0]          diff_r;
  logic [TEMP_W:0]          den_r;
  logic [DIV_NUM_W-1:0]     rpm_prod_r;
  logic signed [15:0]       mprod_r;
  logic                     pz_r;
  logic                     plow_r;
  logic [8:0]               mq_r;
  logic                     msign_r;

  logic                     t_le_low, t_ge_high, mode_ok;
  logic [CNT_W-1:0]         ticks_inc;
  logic [PCT_W-1:0]         man_pct, p_sel;
  logic [3:0]               ppr_eff;
  logic [DIV_NUM_W-1:0]     div_num, div_quo;
  logic [DIV_DEN_W-1:0]     div_den;
  logic                     div_done;
  logic signed [7:0]        pm30;
  logic signed [8:0]        span;
  logic signed [15:0]       mprod_nxt;
  logic [14:0]              mag;
  logic [29:0]              mq_full;
  logic [9:0]               scaled;
  logic [9:0]               duty_sum;
  logic [DUTY_W-1:0]        duty_map;

  always_comb begin
    t_le_low  = temp_r <= temp_low_r;
    t_ge_high = temp_r >= temp_high_r;
    mode_ok   = mode_r inside {MODE_TICK, MODE_TACHO, MODE_TEMP};
    ticks_inc = ticks_r + 1'b1;
    man_pct   = (manual_speed_r > PCT_FULL) ? PCT_FULL : manual_speed_r;
    p_sel     = auto_mode_r ? auto_speed_r : man_pct;
    ppr_eff   = (ppr_r == '0) ? 4'd1 : ppr_r;

    sts.need_rpm  = (mode_r == MODE_TICK) && (ticks_inc >= CNT_W'(SAMPLE_MS));
    sts.need_tdiv = (mode_r == MODE_TEMP) && auto_mode_r && !t_le_low && !t_ge_high;
    sts.need_map  = auto_mode_r ? (mode_r == MODE_TEMP) : mode_ok;
    sts.div_done  = div_done;

    if (cmd.rpm_div) begin
      div_num = rpm_prod_r;
      div_den = DIV_DEN_W'(ppr_eff) * DIV_DEN_W'(ticks_r);
    end else begin
      div_num = DIV_NUM_W'(DIV_NUM_W'(diff_r[TEMP_W-1:0]) * DIV_NUM_W'(PCT_FULL));
      div_den = DIV_DEN_W'(den_r[TEMP_W-1:0]);
    end

    pm30      = $signed({1'b0, p_sel}) - $signed({1'b0, PCT_KNEE});
    span      = $signed({1'b0, max_duty_r}) - $signed({1'b0, start_duty_r});
    mprod_nxt = 16'(pm30) * 16'(span);

    mag     = 15'(mprod_r[15] ? -mprod_r : mprod_r);
    mq_full = 30'(mag) * 30'(RECIP);

    scaled   = msign_r ? -{1'b0, mq_r} : {1'b0, mq_r};
    duty_sum = scaled + {2'b00, start_duty_r};
    if (!auto_mode_r && !fan_enable_r) duty_map = '0;
    else if (pz_r)                     duty_map = MIN_DUTY;
    else if (plow_r)                   duty_map = start_duty_r;
    else                               duty_map = duty_sum[DUTY_W-1:0];
  end

  tpf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.rpm_div | cmd.tmp_div),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_mode_r    <= 1'b0;
      fan_enable_r   <= 1'b0;
      manual_speed_r <= '0;
      temp_low_r     <= 12'sd480;
      temp_high_r    <= 12'sd960;
      start_duty_r   <= 8'd77;
      max_duty_r     <= 8'd255;
      ppr_r          <= 4'd2;
      auto_speed_r   <= '0;
      auto_on_r      <= 1'b0;
      duty_r         <= '0;
      pulses_r       <= '0;
      ticks_r        <= '0;
      rpm_r          <= '0;
      fresh_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_AUTO_MODE:    auto_mode_r    <= cfg_data[0];
          CFG_FAN_ENABLE:   fan_enable_r   <= cfg_data[0];
          CFG_MANUAL_SPEED: manual_speed_r <= cfg_data[PCT_W-1:0];
          CFG_TEMP_LOW:     temp_low_r     <= cfg_data;
          CFG_TEMP_HIGH:    temp_high_r    <= cfg_data;
          CFG_START_DUTY:   start_duty_r   <= cfg_data[DUTY_W-1:0];
          CFG_MAX_DUTY:     max_duty_r     <= cfg_data[DUTY_W-1:0];
          CFG_PULSES_TURN:  ppr_r          <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.capture) fresh_r <= 1'b0;
      if (cmd.exec) begin
        if (mode_r == MODE_TICK) begin
          ticks_r <= ticks_inc;
        end else if (mode_r == MODE_TACHO) begin
          if (pulses_r != '1) pulses_r <= pulses_r + 1'b1;
        end else if (mode_r == MODE_TEMP && auto_mode_r) begin
          if (t_le_low) begin
            auto_speed_r <= '0;
            auto_on_r    <= 1'b0;
          end else if (t_ge_high) begin
            auto_speed_r <= PCT_FULL;
            auto_on_r    <= 1'b1;
          end
        end
      end
      if (cmd.rpm_load) begin
        rpm_r    <= (div_quo[DIV_NUM_W-1:CNT_W] != '0) ? '1 : div_quo[CNT_W-1:0];
        pulses_r <= '0;
        ticks_r  <= '0;
        fresh_r  <= 1'b1;
      end
      if (cmd.speed_load) begin
        auto_speed_r <= div_quo[PCT_W-1:0];
        auto_on_r    <= 1'b1;
      end
      if (cmd.map_fin) duty_r <= duty_map;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      temp_r <= in_temperature;
    end
    if (cmd.exec) begin
      diff_r <= {temp_r[TEMP_W-1], temp_r} - {temp_low_r[TEMP_W-1], temp_low_r};
      den_r  <= {temp_high_r[TEMP_W-1], temp_high_r} - {temp_low_r[TEMP_W-1], temp_low_r};
    end
    if (cmd.rpm_mul) rpm_prod_r <= DIV_NUM_W'(pulses_r) * DIV_NUM_W'(RPM_NUM);
    if (cmd.map_mul) begin
      mprod_r <= mprod_nxt;
      pz_r    <= p_sel == '0;
      plow_r  <= p_sel < PCT_KNEE;
    end
    if (cmd.map_scl) begin
      mq_r    <= mq_full[RECIP_SH+8:RECIP_SH];
      msign_r <= mprod_r[15];
    end
  end

  always_comb begin
    res.duty          = duty_r;
    res.rpm           = rpm_r;
    res.speed_percent = p_sel;
    res.fan_on        = auto_mode_r ? auto_on_r : fan_enable_r;
    res.rpm_fresh     = fresh_r;
  end

endmodule

FILE: rtl/tpf_ctrl.sv
// Controller: sequences one transaction through the datapath steps.
// Depends on tpf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "thermal_pwm_fan_with_tacho_unit_macros.svh"

module tpf_ctrl
  import tpf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    out_free,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_EXEC     = 11'b000_0000_0010,
    ST_RPM_MUL  = 11'b000_0000_0100,
    ST_RPM_DIV  = 11'b000_0000_1000,
    ST_RPM_WAIT = 11'b000_0001_0000,
    ST_TMP_DIV  = 11'b000_0010_0000,
    ST_TMP_WAIT = 11'b000_0100_0000,
    ST_MAP_MUL  = 11'b000_1000_0000,
    ST_MAP_SCL  = 11'b001_0000_0000,
    ST_MAP_FIN  = 11'b010_0000_0000,
    ST_DONE     = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_rpm)       state_nxt = ST_RPM_MUL;
        else if (sts.need_tdiv) state_nxt = ST_TMP_DIV;
        else if (sts.need_map)  state_nxt = ST_MAP_MUL;
        else                    state_nxt = ST_DONE;
      end
      ST_RPM_MUL: begin
        cmd.rpm_mul = 1'b1;
        state_nxt   = ST_RPM_DIV;
      end
      ST_RPM_DIV: begin
        cmd.rpm_div = 1'b1;
        state_nxt   = ST_RPM_WAIT;
      end
      ST_RPM_WAIT: begin
        if (sts.div_done) begin
          cmd.rpm_load = 1'b1;
          state_nxt    = sts.need_map ? ST_MAP_MUL : ST_DONE;
        end
      end
      ST_TMP_DIV: begin
        cmd.tmp_div = 1'b1;
        state_nxt   = ST_TMP_WAIT;
      end
      ST_TMP_WAIT: begin
        if (sts.div_done) begin
          cmd.speed_load = 1'b1;
          state_nxt      = ST_MAP_MUL;
        end
      end
      ST_MAP_MUL: begin
        cmd.map_mul = 1'b1;
        state_nxt   = ST_MAP_SCL;
      end
      ST_MAP_SCL: begin
        cmd.map_scl = 1'b1;
        state_nxt   = ST_MAP_FIN;
      end
      ST_MAP_FIN: begin
        cmd.map_fin = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  `TPF_ASSERT_IMP(a_div_done_waited, sts.div_done,
    (state_r == ST_RPM_WAIT) || (state_r == ST_TMP_WAIT), "divider done outside a wait state")
  `TPF_ASSERT_IMP(a_emit_free, cmd.emit, out_free, "result emitted into a full output register")
  `TPF_ASSERT_NXT(a_rpm_then_map, cmd.rpm_load,
    (state_r == ST_MAP_MUL) || (state_r == ST_DONE), "bad step after rpm update")

endmodule

FILE: sim/fan_result_checker.sv
// Scoreboard for the thermal PWM fan unit: tracks register writes and both channels,
// predicts each result and compares it field by field.
// Depends on tpf_pkg, tpf_in_if and tpf_out_if.
`timescale 1ns / 1ps

module fan_result_checker
  import tpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  tpf_in_if                    in_mon,
  tpf_out_if                   out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   results_pending
);

  logic               auto_mode_r;
  logic               fan_enable_r;
  logic [PCT_W-1:0]   manual_speed_r;
  logic signed [11:0] temp_low_r;
  logic signed [11:0] temp_high_r;
  logic [7:0]         start_duty_r;
  logic [7:0]         max_duty_r;
  logic [3:0]         pulses_turn_r;

  logic [PCT_W-1:0]   auto_speed_r;
  logic               auto_on_r;
  logic [7:0]         duty_r;
  logic [15:0]        window_pulses_r;
  logic [15:0]        window_ticks_r;
  logic [15:0]        rpm_r;

  result_t expected_results[$];

  function automatic int manual_percent();
    return (manual_speed_r > PCT_FULL) ? int'(PCT_FULL) : int'(manual_speed_r);
  endfunction

  function automatic logic [7:0] duty_for_percent(int pct);
    int span_v;
    int d;
    if (pct == 0) return MIN_DUTY;
    if (pct < int'(PCT_KNEE)) return start_duty_r;
    span_v = int'(max_duty_r) - int'(start_duty_r);
    // signed division, truncates toward zero on a descending curve
    d = (pct - int'(PCT_KNEE)) * span_v / int'(PCT_SPAN) + int'(start_duty_r);
    return d[7:0];
  endfunction

  function automatic result_t predict_fan_result(logic [1:0] mode, logic [11:0] temp_raw);
    result_t            r;
    int                 t;
    int                 tl;
    int                 th;
    int                 pct;
    longint unsigned    rate;
    longint unsigned    turns;
    logic               fresh;
    logic               active;
    t      = int'(signed'(temp_raw));
    tl     = int'(temp_low_r);
    th     = int'(temp_high_r);
    fresh  = 1'b0;
    active = 1'b1;
    case (mode)
      MODE_TICK: begin
        window_ticks_r = window_ticks_r + 16'd1;
        if (window_ticks_r >= SAMPLE_MS) begin
          turns = (pulses_turn_r == 4'd0) ? 64'd1 : 64'(pulses_turn_r);
          rate  = 64'(window_pulses_r) * 64'(RPM_NUM) / (turns * 64'(window_ticks_r));
          rpm_r = (rate > 64'd65535) ? 16'hFFFF : rate[15:0];
          window_pulses_r = '0;
          window_ticks_r  = '0;
          fresh = 1'b1;
        end
      end
      MODE_TACHO: begin
        if (window_pulses_r != 16'hFFFF) window_pulses_r = window_pulses_r + 16'd1;
      end
      MODE_TEMP: begin
        if (auto_mode_r) begin
          if (t <= tl) begin
            pct = 0;
            auto_on_r = 1'b0;
          end else if (t >= th) begin
            pct = int'(PCT_FULL);
            auto_on_r = 1'b1;
          end else begin
            pct = (t - tl) * int'(PCT_FULL) / (th - tl);
            auto_on_r = 1'b1;
          end
          auto_speed_r = pct[PCT_W-1:0];
          duty_r = duty_for_percent(pct);
        end
      end
      default: active = 1'b0;
    endcase
    if (active && !auto_mode_r)
      duty_r = fan_enable_r ? duty_for_percent(manual_percent()) : 8'd0;
    r.duty          = duty_r;
    r.rpm           = rpm_r;
    r.speed_percent = auto_mode_r ? auto_speed_r : PCT_W'(manual_percent());
    r.fan_on        = auto_mode_r ? auto_on_r : fan_enable_r;
    r.rpm_fresh     = fresh;
    return r;
  endfunction

  task automatic report_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      auto_mode_r     = 1'b0;
      fan_enable_r    = 1'b0;
      manual_speed_r  = '0;
      temp_low_r      = 12'sd480;
      temp_high_r     = 12'sd960;
      start_duty_r    = 8'd77;
      max_duty_r      = 8'd255;
      pulses_turn_r   = 4'd2;
      auto_speed_r    = '0;
      auto_on_r       = 1'b0;
      duty_r          = '0;
      window_pulses_r = '0;
      window_ticks_r  = '0;
      rpm_r           = '0;
      mismatch_count  = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_AUTO_MODE:    auto_mode_r    = cfg_data[0];
          CFG_FAN_ENABLE:   fan_enable_r   = cfg_data[0];
          CFG_MANUAL_SPEED: manual_speed_r = cfg_data[PCT_W-1:0];
          CFG_TEMP_LOW:     temp_low_r     = signed'(cfg_data[11:0]);
          CFG_TEMP_HIGH:    temp_high_r    = signed'(cfg_data[11:0]);
          CFG_START_DUTY:   start_duty_r   = cfg_data[7:0];
          CFG_MAX_DUTY:     max_duty_r     = cfg_data[7:0];
          CFG_PULSES_TURN:  pulses_turn_r  = cfg_data[3:0];
          default: ;
        endcase
      end
      // result first: it can never belong to a transaction accepted at the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no transaction outstanding");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          report_field("duty", want.duty, out_mon.duty);
          report_field("rpm", want.rpm, out_mon.rpm);
          report_field("speed_percent", want.speed_percent, out_mon.speed_percent);
          report_field("fan_on", want.fan_on, out_mon.fan_on);
          report_field("rpm_fresh", want.rpm_fresh, out_mon.rpm_fresh);
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(predict_fan_result(in_mon.mode, in_mon.temperature));
    end
    results_pending = expected_results.size();
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top for thermal_pwm_fan_with_tacho_unit: clock, reset, register writes,
// directed and random stimulus with random back-pressure, and the final verdict.
// Depends on tpf_pkg, the channel interfaces, the unit and fan_result_checker.
`timescale 1ns / 1ps

module tb_top
  import tpf_pkg::*;
();

  localparam logic [1:0] MODE_RSVD     = 2'd3;
  localparam int         SETTLE_CYCLES = 64;
  localparam int         WINDOW_PULSES = 300;
  localparam logic [3:0] WINDOW_TURNS  = 4'd0;
  localparam int         SEG_ITEMS     = 72;
  localparam logic [5:0][6:0] MANUAL_PROBE = {7'd127, 7'd100, 7'd30, 7'd29, 7'd1, 7'd0};

  typedef struct packed {
    logic        auto_mode;
    logic        fan_enable;
    logic [6:0]  manual_speed;
    logic [11:0] temp_low;
    logic [11:0] temp_high;
    logic [7:0]  start_duty;
    logic [7:0]  max_duty;
    logic [3:0]  pulses_turn;
  } fan_setup_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 calm = 1'b0;
  int                   mismatch_count;
  int                   results_pending;
  fan_setup_t           setup;

  tpf_in_if  in_ch();
  tpf_out_if out_ch();

  thermal_pwm_fan_with_tacho_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fan_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #60_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // result side back-pressure
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic send_item(logic [1:0] m, logic [11:0] t);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.temperature <= t;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  task automatic put_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic apply_setup(fan_setup_t s);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    put_reg(CFG_AUTO_MODE, CFG_W'(s.auto_mode));
    put_reg(CFG_FAN_ENABLE, CFG_W'(s.fan_enable));
    put_reg(CFG_MANUAL_SPEED, CFG_W'(s.manual_speed));
    put_reg(CFG_TEMP_LOW, s.temp_low);
    put_reg(CFG_TEMP_HIGH, s.temp_high);
    put_reg(CFG_START_DUTY, CFG_W'(s.start_duty));
    put_reg(CFG_MAX_DUTY, CFG_W'(s.max_duty));
    put_reg(CFG_PULSES_TURN, CFG_W'(s.pulses_turn));
    cfg_we <= 1'b0;
    setup = s;
  endtask

  function automatic fan_setup_t reset_setup();
    fan_setup_t s;
    s = '{auto_mode: 1'b0, fan_enable: 1'b0, manual_speed: 7'd0,
          temp_low: 12'd480, temp_high: 12'd960, start_duty: 8'd77,
          max_duty: 8'd255, pulses_turn: 4'd2};
    return s;
  endfunction

  function automatic fan_setup_t random_setup();
    fan_setup_t s;
    s.auto_mode    = 1'($urandom_range(0, 1));
    s.fan_enable   = ($urandom_range(0, 3) != 0);
    s.manual_speed = ($urandom_range(0, 3) == 0) ? 7'd127 : 7'($urandom_range(0, 100));
    s.temp_low     = 12'($urandom);
    s.temp_high    = ($urandom_range(0, 2) == 0) ? 12'($urandom)
                                                 : 12'(s.temp_low + $urandom_range(1, 600));
    s.start_duty   = 8'($urandom);
    s.max_duty     = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom);
    s.pulses_turn  = 4'($urandom);
    return s;
  endfunction

  // half the samples land close to the thresholds
  function automatic logic [11:0] pick_temperature();
    int tl;
    int th;
    int lo;
    int hi;
    int v;
    if ($urandom_range(0, 1) == 0) return 12'($urandom);
    tl = int'(signed'(setup.temp_low));
    th = int'(signed'(setup.temp_high));
    lo = ((tl < th) ? tl : th) - 8;
    hi = ((tl < th) ? th : tl) + 8;
    if (lo < -2048) lo = -2048;
    if (hi > 2047) hi = 2047;
    v = lo + int'($urandom_range(0, hi - lo));
    return v[11:0];
  endfunction

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      send_item(MODE_TICK, 12'($urandom));
    else if (pick < 70) send_item(MODE_TACHO, 12'($urandom));
    else if (pick < 95) send_item(MODE_TEMP, pick_temperature());
    else                send_item(MODE_RSVD, 12'($urandom));
  endtask

  // one measurement window's worth of ticks with the pulses spread through it
  task automatic run_window(int pulses);
    int pulses_left;
    int ticks_left;
    pulses_left = pulses;
    ticks_left  = SAMPLE_MS;
    while (pulses_left + ticks_left > 0) begin
      if ($urandom_range(1, pulses_left + ticks_left) <= pulses_left) begin
        send_item(MODE_TACHO, 12'($urandom));
        pulses_left--;
      end else begin
        send_item(MODE_TICK, 12'($urandom));
        ticks_left--;
      end
    end
  endtask

  initial begin
    fan_setup_t s;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_TICK;
    in_ch.temperature <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_AUTO_MODE;
    cfg_data          <= '0;
    setup = reset_setup();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register values straight out of reset
    send_item(MODE_TICK, 12'h000);
    send_item(MODE_TACHO, 12'hFFF);
    send_item(MODE_TEMP, 12'h7FF);
    send_item(MODE_RSVD, 12'h800);

    // auto mode on the default thresholds
    s = reset_setup();
    s.auto_mode = 1'b1;
    apply_setup(s);
    send_item(MODE_TEMP, 12'h800);
    send_item(MODE_TEMP, 12'h7FF);
    send_item(MODE_TEMP, 12'd480);
    send_item(MODE_TEMP, 12'd481);
    send_item(MODE_TEMP, 12'd959);
    send_item(MODE_TEMP, 12'd960);
    send_item(MODE_TEMP, 12'd720);
    send_item(MODE_RSVD, 12'd720);

    // manual speeds around the knee and above full scale
    s = reset_setup();
    s.fan_enable = 1'b1;
    for (int i = 0; i < 6; i++) begin
      s.manual_speed = MANUAL_PROBE[i];
      apply_setup(s);
      send_item(MODE_TICK, 12'h555);
    end
    s.fan_enable   = 1'b0;
    s.manual_speed = 7'd50;
    apply_setup(s);
    send_item(MODE_TACHO, 12'hAAA);

    // descending duty curve
    s.fan_enable   = 1'b1;
    s.manual_speed = 7'd55;
    s.start_duty   = 8'd200;
    s.max_duty     = 8'd10;
    apply_setup(s);
    send_item(MODE_TACHO, 12'h000);

    // thresholds in the wrong order, descending curve in auto mode
    s.auto_mode = 1'b1;
    s.temp_low  = 12'd100;
    s.temp_high = -12'sd100;
    apply_setup(s);
    send_item(MODE_TEMP, 12'd100);
    send_item(MODE_TEMP, 12'd101);
    send_item(MODE_TEMP, 12'h800);

    // a full measurement window back to back, zero pulses per turn
    calm = 1'b1;
    s = random_setup();
    s.pulses_turn = WINDOW_TURNS;
    apply_setup(s);
    run_window(WINDOW_PULSES);

    // random traffic over a spread of register settings
    for (int seg = 0; seg < 8; seg++) begin
      if (seg == 0) begin
        s = '{auto_mode: 1'b1, fan_enable: 1'b0, manual_speed: 7'd0,
              temp_low: 12'h800, temp_high: 12'h7FF, start_duty: 8'd0,
              max_duty: 8'd255, pulses_turn: 4'd1};
      end else if (seg == 1) begin
        s = '{auto_mode: 1'b0, fan_enable: 1'b1, manual_speed: 7'd127,
              temp_low: 12'h7FF, temp_high: 12'h800, start_duty: 8'd255,
              max_duty: 8'd0, pulses_turn: 4'd15};
      end else begin
        s = random_setup();
      end
      apply_setup(s);
      calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if ($urandom_range(0, 59) == 0) drain();
        random_item();
      end
    end
    calm = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: thermal_pwm_fan_with_tacho_unit.f
+incdir+rtl
rtl/tpf_pkg.sv
rtl/tpf_in_if.sv
rtl/tpf_out_if.sv
rtl/tpf_div.sv
rtl/tpf_dp.sv
rtl/tpf_ctrl.sv
rtl/thermal_pwm_fan_with_tacho_unit.sv
sim/fan_result_checker.sv
sim/tb_top.sv
